@@ rtl/bcis_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package bcis_pkg;

    // Step applied by the panel time buttons, in milliseconds.
    localparam int TIME_STEP_MS = 1000;

    // Configuration port geometry.
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_INIT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_MIN   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_MAX   = 2'd3;

    // Configuration reset values.
    localparam logic [15:0] DEBOUNCE_RST  = 16'd250;
    localparam logic [14:0] TIME_INIT_RST = 15'd7000;
    localparam logic [14:0] TIME_MIN_RST  = 15'd1000;
    localparam logic [15:0] TIME_MAX_RST  = 16'd30000;

    // Stop reason codes.
    localparam logic [2:0] REASON_NONE       = 3'd0;
    localparam logic [2:0] REASON_TIME_DONE  = 3'd1;
    localparam logic [2:0] REASON_DOOR       = 3'd2;
    localparam logic [2:0] REASON_CELL_SHAFT = 3'd3;
    localparam logic [2:0] REASON_CELL_AVAIL = 3'd4;
    localparam logic [2:0] REASON_SHAFT_GONE = 3'd5;

    // One tick of sampled inputs.
    typedef struct packed {
        logic mode_manual;
        logic shaft_absent;
        logic door_open;
        logic cell_part_placed;
        logic cell_on;
        logic cell_fault;
        logic cell_in_auto;
        logic btn_less_time;
        logic btn_more_time;
    } t_in;

    // One result beat.
    typedef struct packed {
        logic        relay_drive;
        logic        blasting_out;
        logic        machine_safe_out;
        logic        shaft_present_out;
        logic        manual_active;
        logic [2:0]  stop_reason;
        logic [31:0] finished_count;
        logic [15:0] blast_time_ms;
    } t_out;

    // Configuration registers.
    typedef struct packed {
        logic [15:0] debounce_ms;
        logic [14:0] time_init_ms;
        logic [14:0] time_min_ms;
        logic [15:0] time_max_ms;
    } t_cfg;

    // Sequencer state carried from tick to tick.
    typedef struct packed {
        logic        mode_last;
        logic        blasting;
        logic        shaft_absent_last;
        logic        door_open_last;
        logic        cell_sip_last;
        logic        cycle_handled;
        logic [15:0] since_start;
        logic [15:0] blast_time;
        logic [31:0] count;
        logic        safe_out;
        logic        shaft_out;
    } t_state;

endpackage

`default_nettype wire

@@ rtl/bcis_in_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface bcis_in_if import bcis_pkg::*;;
    logic valid;
    logic ready;
    t_in  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/bcis_out_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface bcis_out_if import bcis_pkg::*;;
    logic valid;
    logic ready;
    t_out data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/blast_cycle_interlock_sequencer.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Blast cycle interlock sequencer.
// Input channel i_in: one beat per millisecond tick carrying the sampled mode
// switch, shaft and door sensors, robot-cell handshake lines and panel buttons.
// Output channel o_out: one beat per input beat with the relay drive, blasting
// line, cell indications, current mode, stop reason, finished-blast count and
// current blast time.
// Configuration is written through i_cfg_we / i_cfg_idx / i_cfg_data (the
// user must write it only while no beat is in flight; the block does not
// enforce this): debounce, initial blast time (also loads the current time),
// minimum and maximum blast time.
// A beat in the input register passes through the tick logic into the result
// register once that register is free, and o_out.valid then rises.
// Throughput is one beat per cycle while o_out.ready stays high; the tick logic
// is a single combinational pass between the input and result registers.
// Reset puts the sequencer idle, loads the configuration defaults and the
// initial blast time, and empties both registers.
// When the receiver stalls, the result register holds its beat and the input
// register still takes one more beat before i_in.ready drops.
module blast_cycle_interlock_sequencer import bcis_pkg::*; (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    bcis_in_if.sink              i_in,
    bcis_out_if.source           o_out,
    input  wire                  i_cfg_we,
    input  wire [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire [CFG_DATA_W-1:0] i_cfg_data
);

    t_in    r_in;
    logic   r_in_valid;
    t_out   r_out;
    logic   r_out_valid;
    t_state r_state;
    t_cfg   r_cfg;
    t_state n_state;
    t_out   n_out;
    logic   out_free;
    logic   step_fire;

    // Handshake between the two register stages.
    assign out_free   = !r_out_valid || o_out.ready;
    assign step_fire  = r_in_valid && out_free;
    assign i_in.ready = !r_in_valid || step_fire;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    bcis_step u_step (
        .i_cfg   (r_cfg),
        .i_state (r_state),
        .i_item  (r_in),
        .o_state (n_state),
        .o_res   (n_out)
    );

    // Valid flags, sequencer state and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid                <= 1'b0;
            r_out_valid               <= 1'b0;
            r_cfg.debounce_ms         <= DEBOUNCE_RST;
            r_cfg.time_init_ms        <= TIME_INIT_RST;
            r_cfg.time_min_ms         <= TIME_MIN_RST;
            r_cfg.time_max_ms         <= TIME_MAX_RST;
            r_state.mode_last         <= 1'b1;
            r_state.blasting          <= 1'b0;
            r_state.shaft_absent_last <= 1'b1;
            r_state.door_open_last    <= 1'b1;
            r_state.cell_sip_last     <= 1'b0;
            r_state.cycle_handled     <= 1'b1;
            r_state.since_start       <= '0;
            r_state.blast_time        <= {1'b0, TIME_INIT_RST};
            r_state.count             <= '0;
            r_state.safe_out          <= 1'b0;
            r_state.shaft_out         <= 1'b0;
        end else begin
            if (i_in.valid && i_in.ready) begin
                r_in_valid <= 1'b1;
            end else if (step_fire) begin
                r_in_valid <= 1'b0;
            end

            if (step_fire) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_DEBOUNCE: begin
                        r_cfg.debounce_ms <= i_cfg_data;
                    end
                    CFG_TIME_INIT: begin
                        r_cfg.time_init_ms <= i_cfg_data[14:0];
                        r_state.blast_time <= {1'b0, i_cfg_data[14:0]};
                    end
                    CFG_TIME_MIN: begin
                        r_cfg.time_min_ms <= i_cfg_data[14:0];
                    end
                    CFG_TIME_MAX: begin
                        r_cfg.time_max_ms <= i_cfg_data;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in <= i_in.data;
        end
        if (step_fire) begin
            r_out <= n_out;
        end
    end

    // A counted stop never leaves the blast running.
    a_stop_ends_blast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.stop_reason != REASON_NONE) |-> !r_out.blasting_out)
        else $error("stop reason reported while still blasting");

    // The finished count advances by one exactly on a counted stop.
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step_fire |=> (r_state.count ==
            $past(r_state.count) + 32'($past(n_out.stop_reason) != REASON_NONE)))
        else $error("finished count out of step with stop reasons");

    // An empty result register never blocks the input side.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> i_in.ready)
        else $error("input stalled while result register empty");

    // Relay drive and blasting line always agree.
    a_relay_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.relay_drive == r_out.blasting_out))
        else $error("relay drive and blasting line disagree");

endmodule

`default_nettype wire

@@ rtl/bcis_step.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bcis_step import bcis_pkg::*; (
    input  wire t_cfg   i_cfg,
    input  wire t_state i_state,
    input  wire t_in    i_item,
    output t_state      o_state,
    output t_out        o_res
);

    logic        blast;
    logic        avail;
    logic [15:0] elapsed;
    logic [2:0]  reason;
    logic [15:0] bt;
    logic [16:0] inc_sum;

    // One tick of the blast sequencer: starts, stops, time buttons.
    always_comb begin
        o_state = i_state;
        blast   = i_state.blasting;
        elapsed = i_state.since_start;
        reason  = REASON_NONE;
        avail   = i_item.cell_on && i_item.cell_in_auto && !i_item.cell_fault;

        // A mode change drops any running blast without counting it.
        if (i_item.mode_manual != i_state.mode_last) begin
            blast = 1'b0;
        end

        if (i_item.mode_manual) begin
            // Manual start on the shaft sensor's present edge.
            if (!blast && (elapsed > i_cfg.debounce_ms) && !i_item.door_open &&
                i_state.shaft_absent_last && !i_item.shaft_absent) begin
                blast   = 1'b1;
                elapsed = '0;
            end
            if (blast) begin
                if (i_item.door_open) begin
                    reason = REASON_DOOR;
                end else if (elapsed > i_state.blast_time) begin
                    reason = REASON_TIME_DONE;
                end else if (i_item.shaft_absent) begin
                    reason = REASON_SHAFT_GONE;
                end
            end
        end else begin
            // Indications to the cell follow sensor edges in auto mode only.
            if (i_item.door_open != i_state.door_open_last) begin
                o_state.safe_out = !i_item.door_open;
            end
            if (i_item.shaft_absent != i_state.shaft_absent_last) begin
                o_state.shaft_out = !i_item.shaft_absent;
            end
            if (i_item.cell_part_placed && !i_state.cell_sip_last) begin
                o_state.cycle_handled = 1'b0;
            end
            // Auto start, once per rising edge of the cell's shaft-in-place.
            if (avail && !o_state.cycle_handled && !blast &&
                (elapsed > i_cfg.debounce_ms) && !i_item.door_open &&
                i_item.cell_part_placed && !i_item.shaft_absent) begin
                blast                 = 1'b1;
                o_state.cycle_handled = 1'b1;
                elapsed               = '0;
            end
            if (blast) begin
                if (i_item.door_open) begin
                    reason = REASON_DOOR;
                end else if (!i_item.cell_part_placed) begin
                    reason = REASON_CELL_SHAFT;
                end else if (!avail) begin
                    reason = REASON_CELL_AVAIL;
                end else if (elapsed > i_state.blast_time) begin
                    reason = REASON_TIME_DONE;
                end else if (i_item.shaft_absent) begin
                    reason = REASON_SHAFT_GONE;
                end
            end
            o_state.cell_sip_last = i_item.cell_part_placed;
        end

        // Any counted stop ends the blast.
        if (reason != REASON_NONE) begin
            blast = 1'b0;
        end
        o_state.count = i_state.count + 32'(reason != REASON_NONE);

        // Time buttons: decrement first, then increment with clamping.
        bt = i_state.blast_time;
        if (i_item.btn_less_time) begin
            if (bt <= 16'(TIME_STEP_MS)) begin
                bt = {1'b0, i_cfg.time_min_ms};
            end else begin
                bt = bt - 16'(TIME_STEP_MS);
            end
        end
        inc_sum = {1'b0, bt} + 17'(TIME_STEP_MS);
        if (i_item.btn_more_time) begin
            if (inc_sum > {1'b0, i_cfg.time_max_ms}) begin
                bt = i_cfg.time_max_ms;
            end else begin
                bt = inc_sum[15:0];
            end
        end
        o_state.blast_time = bt;

        // Edge memories and the saturating tick counter.
        o_state.blasting          = blast;
        o_state.shaft_absent_last = i_item.shaft_absent;
        o_state.door_open_last    = i_item.door_open;
        o_state.mode_last         = i_item.mode_manual;
        o_state.since_start       = (elapsed != 16'hFFFF) ? elapsed + 16'd1 : elapsed;

        // Result beat.
        o_res.relay_drive       = blast;
        o_res.blasting_out      = blast;
        o_res.machine_safe_out  = o_state.safe_out;
        o_res.shaft_present_out = o_state.shaft_out;
        o_res.manual_active     = i_item.mode_manual;
        o_res.stop_reason       = reason;
        o_res.finished_count    = o_state.count;
        o_res.blast_time_ms     = bt;
    end

endmodule

`default_nettype wire
